// ===== hw/rtl/fcou_pkg.sv =====
// ----------------------------------------------------------------------------
// fcou_pkg
// Shared types, constants and tables of the fly camera orientation update.
// ----------------------------------------------------------------------------
package fcou_pkg;

    localparam int CORDIC_STEPS_DEF = 16;

    localparam int ONE_Q14   = 16384;
    localparam int ONE_Q30   = 1073741824;
    localparam int YAW_SPAN  = 46080;
    localparam int YAW_HALF  = 23040;
    localparam int YAW_BIAS  = YAW_SPAN * 128;
    localparam int PITCH_LIM = 11392;
    localparam int ZOOM_MIN  = 128;
    localparam int ZOOM_MAX  = 5760;
    localparam int ANG_90    = 11520;
    localparam int YAW_RST   = -11520;
    localparam int CORDIC_K  = 652032874;
    localparam int SPEED_RST = 640;
    localparam int SENS_RST  = 410;

    localparam int SD_ITERS = 32;
    localparam int SD_CW    = $clog2(SD_ITERS);

    localparam logic [2:0] CFG_START_X     = 3'd0;
    localparam logic [2:0] CFG_START_Y     = 3'd1;
    localparam logic [2:0] CFG_START_Z     = 3'd2;
    localparam logic [2:0] CFG_START_YAW   = 3'd3;
    localparam logic [2:0] CFG_START_PITCH = 3'd4;
    localparam logic [2:0] CFG_MOVE_SPEED  = 3'd5;
    localparam logic [2:0] CFG_TURN_SENS   = 3'd6;

    localparam logic [1:0] ACT_MOVE    = 2'd0;
    localparam logic [1:0] ACT_TURN    = 2'd1;
    localparam logic [1:0] ACT_ZOOM    = 2'd2;
    localparam logic [1:0] ACT_RESTART = 2'd3;

    localparam logic [2:0] DIR_FWD   = 3'd0;
    localparam logic [2:0] DIR_BACK  = 3'd1;
    localparam logic [2:0] DIR_LEFT  = 3'd2;
    localparam logic [2:0] DIR_RIGHT = 3'd3;
    localparam logic [2:0] DIR_UP    = 3'd4;
    localparam logic [2:0] DIR_DOWN  = 3'd5;

    localparam logic [2:0] GRP_POS   = 3'd0;
    localparam logic [2:0] GRP_FRONT = 3'd1;
    localparam logic [2:0] GRP_RIGHT = 3'd2;
    localparam logic [2:0] GRP_UP    = 3'd3;
    localparam logic [2:0] GRP_ANG   = 3'd4;

    localparam logic [1:0] NSEL_FRONT = 2'd0;
    localparam logic [1:0] NSEL_RIGHT = 2'd1;
    localparam logic [1:0] NSEL_UP    = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_OFS, S_MOVE, S_TX, S_TY, S_WRAP, S_CR_INIT, S_CR_STEP,
        S_F0, S_F1, S_F2, S_N_SQ, S_SQ_GO, S_SQ_WAIT, S_DIV_GO, S_DIV_WAIT,
        S_N_DONE, S_U0, S_U1, S_U2, S_U3, S_EMIT
    } t_state;

    typedef enum logic {
        SD_SQRT,
        SD_DIV
    } t_sd_mode;

    typedef struct packed {
        logic     start;
        t_sd_mode mode;
    } t_sd_ctrl;

    function automatic logic signed [31:0] atan_q22(input logic [4:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:    v = 32'sd188743680;
            5'd1:    v = 32'sd111421900;
            5'd2:    v = 32'sd58872272;
            5'd3:    v = 32'sd29884485;
            5'd4:    v = 32'sd15000234;
            5'd5:    v = 32'sd7507429;
            5'd6:    v = 32'sd3754631;
            5'd7:    v = 32'sd1877430;
            5'd8:    v = 32'sd938729;
            5'd9:    v = 32'sd469366;
            5'd10:   v = 32'sd234683;
            5'd11:   v = 32'sd117342;
            5'd12:   v = 32'sd58671;
            5'd13:   v = 32'sd29335;
            5'd14:   v = 32'sd14668;
            5'd15:   v = 32'sd7334;
            5'd16:   v = 32'sd3667;
            5'd17:   v = 32'sd1833;
            5'd18:   v = 32'sd917;
            5'd19:   v = 32'sd458;
            5'd20:   v = 32'sd229;
            5'd21:   v = 32'sd115;
            5'd22:   v = 32'sd57;
            5'd23:   v = 32'sd29;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] to_q14(input logic signed [31:0] v);
        logic signed [32:0] t;
        logic signed [16:0] s;
        logic signed [15:0] r;
        t = {v[31], v} + 33'sd32768;
        s = t[32:16];
        if (s > 17'sd32767) begin
            r = 16'sh7fff;
        end else if (s < -17'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = s[15:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/fcou_sqdiv.sv =====
// ----------------------------------------------------------------------------
// fcou_sqdiv
// Iterative square root and unsigned divide, one result bit per cycle.
// ----------------------------------------------------------------------------
module fcou_sqdiv import fcou_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_sd_ctrl    i_ctrl,
    input  logic [63:0] i_opa,
    input  logic [31:0] i_opb,
    output logic        o_done,
    output logic [31:0] o_res
);

    logic             r_busy;
    logic             r_done;
    t_sd_mode         r_mode;
    logic [SD_CW-1:0] r_cnt;
    logic [63:0]      r_n;
    logic [63:0]      r_r;
    logic [63:0]      r_b;
    logic [31:0]      r_rem;
    logic [31:0]      r_dvd;
    logic [31:0]      r_q;
    logic [31:0]      r_d;

    logic [63:0] sq_t;
    logic        sq_ge;
    logic [32:0] dv_t;
    logic        dv_ge;
    logic [32:0] dv_s;

    assign sq_t  = r_r + r_b;
    assign sq_ge = r_n >= sq_t;
    assign dv_t  = {r_rem, r_dvd[31]};
    assign dv_ge = dv_t >= {1'b0, r_d};
    assign dv_s  = dv_t - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_mode <= i_ctrl.mode;
                r_n    <= i_opa;
                r_r    <= '0;
                r_b    <= 64'd1 << 62;
                r_rem  <= i_opa[63:32];
                r_dvd  <= i_opa[31:0];
                r_q    <= '0;
                r_d    <= i_opb;
            end else if (r_busy) begin
                if (sq_ge) begin
                    r_n <= r_n - sq_t;
                    r_r <= (r_r >> 1) + r_b;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_b   <= r_b >> 2;
                r_rem <= dv_ge ? dv_s[31:0] : dv_t[31:0];
                r_dvd <= {r_dvd[30:0], 1'b0};
                r_q   <= {r_q[30:0], dv_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == SD_CW'(SD_ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = (r_mode == SD_SQRT) ? r_r[31:0] : r_q;

endmodule

// ===== hw/rtl/fly_camera_orientation_update.sv =====
// ----------------------------------------------------------------------------
// fly_camera_orientation_update
// Fly camera state: position, yaw, pitch, zoom and front, right, up vectors.
//
// The input channel (i_in_valid / o_in_stall) takes one event transaction:
// move, turn, zoom or restart. Every event answers with five result
// transactions on the output channel (o_out_valid / i_out_stall): position,
// front, right, up and the angle group, the last one flagged by
// o_last_of_run. One event is in work at a time; o_in_stall stays high from
// acceptance until the fifth result is taken.
// Turn and restart rebuild the vectors with the shared CORDIC rotator, the
// shared multiplier and the bit-serial square root and divide unit (three
// normalizations, each a square root and up to three divides). The results
// then leave at one per cycle while the receiver does not stall; a stall
// holds the current result. Configuration writes take effect on the next
// restart (speed and sensitivity on the next event). Reset loads the default
// camera and register values.
// ----------------------------------------------------------------------------
module fly_camera_orientation_update import fcou_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_action,
    input  logic [2:0]         i_move_dir,
    input  logic [15:0]        i_delta_time,
    input  logic signed [15:0] i_x_offset,
    input  logic signed [15:0] i_y_offset,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_which_group,
    output logic signed [31:0] o_comp_a,
    output logic signed [31:0] o_comp_b,
    output logic signed [31:0] o_comp_c,
    output logic               o_last_of_run
);

    localparam int IW = $clog2(CORDIC_STEPS);

    logic signed [31:0] r_start_x, r_start_y, r_start_z;
    logic signed [15:0] r_start_yaw;
    logic signed [14:0] r_start_pitch;
    logic [15:0]        r_speed, r_sens;

    logic signed [31:0] r_pos [3];
    logic signed [15:0] r_yaw, r_pitch, r_zoom;
    logic signed [15:0] r_front [3];
    logic signed [15:0] r_right [3];
    logic signed [15:0] r_up [3];

    logic [1:0]         r_act;
    logic [2:0]         r_dir;
    logic [15:0]        r_dt;
    logic signed [15:0] r_xo, r_yo;

    t_state             r_state, n_state;
    logic [1:0]         r_idx;
    logic               r_sel;
    logic [1:0]         r_nsel;
    logic [2:0]         r_k;
    logic [IW-1:0]      r_it;
    logic [2:0]         r_grp;
    logic [31:0]        r_ofs;
    logic [23:0]        r_wrap;
    logic signed [33:0] r_cx, r_cy;
    logic signed [31:0] r_cz;
    logic               r_neg;
    logic signed [31:0] r_cosv [2];
    logic signed [31:0] r_sinv [2];
    logic signed [63:0] r_acc;
    logic [62:0]        r_sum;
    logic [31:0]        r_len;
    logic               r_fall;
    logic signed [31:0] r_v [3];
    logic signed [31:0] r_nout [3];
    logic signed [31:0] r_fn [3];
    logic signed [31:0] r_rn [3];

    logic signed [33:0] m_a, m_b;
    logic signed [67:0] m_p;

    t_sd_ctrl           sd_ctrl;
    logic [63:0]        sd_opa;
    logic               sd_done;
    logic [31:0]        sd_res;

    fcou_sqdiv u_sqdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (sd_ctrl),
        .i_opa   (sd_opa),
        .i_opb   (r_len),
        .o_done  (sd_done),
        .o_res   (sd_res)
    );

    // ---- shared multiplier operand select ----
    logic signed [15:0] mv_v;
    logic               mv_neg;

    always_comb begin
        case (r_dir) inside
            DIR_FWD, DIR_BACK:   mv_v = r_front[r_idx];
            DIR_LEFT, DIR_RIGHT: mv_v = r_right[r_idx];
            default:             mv_v = r_up[r_idx];
        endcase
        case (r_dir) inside
            DIR_BACK, DIR_LEFT, DIR_DOWN: mv_neg = 1'b1;
            default:                      mv_neg = 1'b0;
        endcase
    end

    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            S_OFS: begin
                m_a = {18'd0, r_speed};
                m_b = {18'd0, r_dt};
            end
            S_MOVE: begin
                m_a = 34'(mv_v);
                m_b = {2'd0, r_ofs};
            end
            S_TX: begin
                m_a = 34'(r_xo);
                m_b = {18'd0, r_sens};
            end
            S_TY: begin
                m_a = 34'(r_yo);
                m_b = {18'd0, r_sens};
            end
            S_F0: begin
                m_a = 34'(r_cosv[0]);
                m_b = 34'(r_cosv[1]);
            end
            S_F1: begin
                m_a = 34'(r_sinv[0]);
                m_b = 34'(r_cosv[1]);
            end
            S_N_SQ: begin
                m_a = 34'(r_v[r_idx]);
                m_b = 34'(r_v[r_idx]);
            end
            S_U0: begin
                m_a = -34'(r_rn[2]);
                m_b = 34'(r_fn[1]);
            end
            S_U1: begin
                m_a = 34'(r_rn[2]);
                m_b = 34'(r_fn[0]);
            end
            S_U2: begin
                m_a = 34'(r_rn[0]);
                m_b = 34'(r_fn[2]);
            end
            S_U3: begin
                m_a = 34'(r_rn[0]);
                m_b = 34'(r_fn[1]);
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    assign m_p = m_a * m_b;

    // ---- datapath helpers ----
    logic signed [48:0] mv_r;
    logic signed [26:0] mv_step;
    logic signed [33:0] mv_sum;
    logic signed [31:0] mv_sat;

    assign mv_r    = m_p[48:0] + 49'sd2097152;
    assign mv_step = mv_r[48:22];
    assign mv_sum  = mv_neg ? (34'(r_pos[r_idx]) - 34'(mv_step))
                            : (34'(r_pos[r_idx]) + 34'(mv_step));

    always_comb begin
        if (mv_sum > 34'sh07fffffff) begin
            mv_sat = 32'sh7fffffff;
        end else if (mv_sum < -34'sh080000000) begin
            mv_sat = 32'sh80000000;
        end else begin
            mv_sat = mv_sum[31:0];
        end
    end

    logic signed [33:0] tr_r;
    logic signed [24:0] tr_d;
    logic signed [24:0] yaw_sum;
    logic signed [24:0] pit_sum;
    logic signed [15:0] pit_cl;
    logic signed [15:0] spit_cl;
    logic signed [19:0] zm_sum;
    logic signed [15:0] zm_cl;

    assign tr_r    = m_p[33:0] + 34'sd256;
    assign tr_d    = tr_r[33:9];
    assign yaw_sum = 25'(r_yaw) + tr_d + 25'(YAW_HALF + YAW_BIAS);
    assign pit_sum = 25'(r_pitch) + tr_d;
    assign zm_sum  = 20'(r_zoom) - (20'(r_yo) <<< 3);

    always_comb begin
        if (pit_sum > 25'(PITCH_LIM)) begin
            pit_cl = 16'(PITCH_LIM);
        end else if (pit_sum < -25'(PITCH_LIM)) begin
            pit_cl = -16'(PITCH_LIM);
        end else begin
            pit_cl = pit_sum[15:0];
        end
        if (r_start_pitch > 15'(PITCH_LIM)) begin
            spit_cl = 16'(PITCH_LIM);
        end else if (r_start_pitch < -15'(PITCH_LIM)) begin
            spit_cl = -16'(PITCH_LIM);
        end else begin
            spit_cl = 16'(r_start_pitch);
        end
        if (zm_sum > 20'(ZOOM_MAX)) begin
            zm_cl = 16'(ZOOM_MAX);
        end else if (zm_sum < 20'(ZOOM_MIN)) begin
            zm_cl = 16'(ZOOM_MIN);
        end else begin
            zm_cl = zm_sum[15:0];
        end
    end

    logic [23:0] wr_span;
    logic [23:0] wr_next;
    logic [23:0] wr_yaw;

    assign wr_span = 24'(YAW_SPAN) << r_k;
    assign wr_next = (r_wrap >= wr_span) ? (r_wrap - wr_span) : r_wrap;
    assign wr_yaw  = wr_next - 24'(YAW_HALF);

    logic signed [15:0] cr_ang;
    logic signed [15:0] cr_angf;
    logic               cr_negf;
    logic signed [33:0] cr_sx, cr_sy, cr_nx, cr_ny, cr_cx, cr_cy;
    logic signed [31:0] cr_at, cr_nz;
    logic               cr_last;

    always_comb begin
        cr_ang = r_sel ? r_pitch : r_yaw;
        if (cr_ang > 16'(ANG_90)) begin
            cr_angf = cr_ang - 16'(2 * ANG_90);
            cr_negf = 1'b1;
        end else if (cr_ang < -16'(ANG_90)) begin
            cr_angf = cr_ang + 16'(2 * ANG_90);
            cr_negf = 1'b1;
        end else begin
            cr_angf = cr_ang;
            cr_negf = 1'b0;
        end
    end

    assign cr_sx = r_cx >>> r_it;
    assign cr_sy = r_cy >>> r_it;
    assign cr_at = atan_q22(5'(r_it));
    assign cr_nx = r_cz[31] ? (r_cx + cr_sy) : (r_cx - cr_sy);
    assign cr_ny = r_cz[31] ? (r_cy - cr_sx) : (r_cy + cr_sx);
    assign cr_nz = r_cz[31] ? (r_cz + cr_at) : (r_cz - cr_at);
    assign cr_cx = r_neg ? -cr_nx : cr_nx;
    assign cr_cy = r_neg ? -cr_ny : cr_ny;
    assign cr_last = (r_it == IW'(CORDIC_STEPS - 1));

    logic signed [32:0] dv_abs;
    logic signed [31:0] dv_q;
    logic signed [63:0] u_diff;
    logic signed [31:0] nw [3];

    assign dv_abs = r_v[r_idx][31] ? -33'(r_v[r_idx]) : 33'(r_v[r_idx]);
    assign dv_q   = r_v[r_idx][31] ? -$signed(sd_res) : $signed(sd_res);
    assign u_diff = r_acc - m_p[63:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nw[i] = r_nout[i];
        end
        if (r_fall) begin
            nw[0] = '0;
            nw[1] = '0;
            nw[2] = '0;
            case (r_nsel)
                NSEL_FRONT: nw[2] = -32'(ONE_Q30);
                NSEL_RIGHT: nw[0] = 32'(ONE_Q30);
                default:    nw[1] = 32'(ONE_Q30);
            endcase
        end
    end

    always_comb begin
        sd_ctrl.start = (r_state == S_SQ_GO) || (r_state == S_DIV_GO);
        sd_ctrl.mode  = (r_state == S_DIV_GO) ? SD_DIV : SD_SQRT;
        sd_opa        = (r_state == S_DIV_GO) ? (64'(dv_abs) << 30) : {1'b0, r_sum};
    end

    // ---- sequencer ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                unique case (r_act)
                    ACT_MOVE:    n_state = (r_dir > DIR_DOWN) ? S_EMIT : S_OFS;
                    ACT_TURN:    n_state = S_TX;
                    ACT_ZOOM:    n_state = S_EMIT;
                    ACT_RESTART: n_state = S_WRAP;
                    default:     n_state = S_EMIT;
                endcase
            end
            S_OFS:     n_state = S_MOVE;
            S_MOVE:    n_state = (r_idx == 2'd2) ? S_EMIT : S_MOVE;
            S_TX:      n_state = S_TY;
            S_TY:      n_state = S_WRAP;
            S_WRAP:    n_state = (r_k == 3'd0) ? S_CR_INIT : S_WRAP;
            S_CR_INIT: n_state = S_CR_STEP;
            S_CR_STEP: begin
                if (cr_last) begin
                    n_state = r_sel ? S_F0 : S_CR_INIT;
                end
            end
            S_F0:      n_state = S_F1;
            S_F1:      n_state = S_F2;
            S_F2:      n_state = S_N_SQ;
            S_N_SQ:    n_state = (r_idx == 2'd2) ? S_SQ_GO : S_N_SQ;
            S_SQ_GO:   n_state = S_SQ_WAIT;
            S_SQ_WAIT: begin
                if (sd_done) begin
                    n_state = (sd_res == 32'd0) ? S_N_DONE : S_DIV_GO;
                end
            end
            S_DIV_GO:  n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (sd_done) begin
                    n_state = (r_idx == 2'd2) ? S_N_DONE : S_DIV_GO;
                end
            end
            S_N_DONE: begin
                unique case (r_nsel)
                    NSEL_FRONT: n_state = S_N_SQ;
                    NSEL_RIGHT: n_state = S_U0;
                    default:    n_state = S_EMIT;
                endcase
            end
            S_U0:      n_state = S_U1;
            S_U1:      n_state = S_U2;
            S_U2:      n_state = S_U3;
            S_U3:      n_state = S_N_SQ;
            S_EMIT: begin
                if (!i_out_stall && r_grp == GRP_ANG) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // ---- configuration ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x     <= '0;
            r_start_y     <= '0;
            r_start_z     <= '0;
            r_start_yaw   <= 16'(YAW_RST);
            r_start_pitch <= '0;
            r_speed       <= 16'(SPEED_RST);
            r_sens        <= 16'(SENS_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_X:     r_start_x     <= i_cfg_data;
                CFG_START_Y:     r_start_y     <= i_cfg_data;
                CFG_START_Z:     r_start_z     <= i_cfg_data;
                CFG_START_YAW:   r_start_yaw   <= i_cfg_data[15:0];
                CFG_START_PITCH: r_start_pitch <= i_cfg_data[14:0];
                CFG_MOVE_SPEED:  r_speed       <= i_cfg_data[15:0];
                CFG_TURN_SENS:   r_sens        <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // ---- datapath ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= '0;
            end
            r_yaw      <= 16'(YAW_RST);
            r_pitch    <= '0;
            r_zoom     <= 16'(ZOOM_MAX);
            r_front[0] <= '0;
            r_front[1] <= '0;
            r_front[2] <= -16'(ONE_Q14);
            r_right[0] <= 16'(ONE_Q14);
            r_right[1] <= '0;
            r_right[2] <= '0;
            r_up[0]    <= '0;
            r_up[1]    <= 16'(ONE_Q14);
            r_up[2]    <= '0;
            r_grp      <= GRP_POS;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_act <= i_action;
                    r_dir <= i_move_dir;
                    r_dt  <= i_delta_time;
                    r_xo  <= i_x_offset;
                    r_yo  <= i_y_offset;
                    r_grp <= GRP_POS;
                end
                S_DISP: begin
                    r_k <= 3'd7;
                    if (r_act == ACT_ZOOM) begin
                        r_zoom <= zm_cl;
                    end
                    if (r_act == ACT_RESTART) begin
                        r_pos[0] <= r_start_x;
                        r_pos[1] <= r_start_y;
                        r_pos[2] <= r_start_z;
                        r_pitch  <= spit_cl;
                        r_zoom   <= 16'(ZOOM_MAX);
                        r_wrap   <= 24'(25'(r_start_yaw) + 25'(YAW_HALF + YAW_BIAS));
                    end
                end
                S_OFS: begin
                    r_ofs <= m_p[31:0];
                    r_idx <= 2'd0;
                end
                S_MOVE: begin
                    r_pos[r_idx] <= mv_sat;
                    r_idx        <= r_idx + 2'd1;
                end
                S_TX: r_wrap <= yaw_sum[23:0];
                S_TY: r_pitch <= pit_cl;
                S_WRAP: begin
                    r_wrap <= wr_next;
                    r_k    <= r_k - 3'd1;
                    r_sel  <= 1'b0;
                    if (r_k == 3'd0) begin
                        r_yaw <= wr_yaw[15:0];
                    end
                end
                S_CR_INIT: begin
                    r_cx  <= 34'(CORDIC_K);
                    r_cy  <= '0;
                    r_cz  <= {{16{cr_angf[15]}}, cr_angf} <<< 15;
                    r_neg <= cr_negf;
                    r_it  <= '0;
                end
                S_CR_STEP: begin
                    r_cx <= cr_nx;
                    r_cy <= cr_ny;
                    r_cz <= cr_nz;
                    r_it <= r_it + 1'b1;
                    if (cr_last) begin
                        r_cosv[r_sel] <= cr_cx[31:0];
                        r_sinv[r_sel] <= cr_cy[31:0];
                        r_sel         <= 1'b1;
                    end
                end
                S_F0: r_acc <= m_p[63:0];
                S_F1: begin
                    r_v[0] <= r_acc[61:30];
                    r_acc  <= m_p[63:0];
                end
                S_F2: begin
                    r_v[2] <= r_acc[61:30];
                    r_v[1] <= r_sinv[1];
                    r_nsel <= NSEL_FRONT;
                    r_idx  <= 2'd0;
                end
                S_N_SQ: begin
                    r_sum <= ((r_idx == 2'd0) ? 63'd0 : r_sum) + m_p[62:0];
                    r_idx <= r_idx + 2'd1;
                end
                S_SQ_WAIT: begin
                    r_len  <= sd_res;
                    r_fall <= (sd_res == 32'd0);
                    r_idx  <= 2'd0;
                end
                S_DIV_WAIT: begin
                    if (sd_done) begin
                        r_nout[r_idx] <= dv_q;
                        r_idx         <= r_idx + 2'd1;
                    end
                end
                S_N_DONE: begin
                    r_idx <= 2'd0;
                    unique case (r_nsel)
                        NSEL_FRONT: begin
                            for (int i = 0; i < 3; i++) begin
                                r_fn[i] <= nw[i];
                            end
                            r_v[0] <= -nw[2];
                            r_v[1] <= '0;
                            r_v[2] <= nw[0];
                            r_nsel <= NSEL_RIGHT;
                        end
                        NSEL_RIGHT: begin
                            for (int i = 0; i < 3; i++) begin
                                r_rn[i] <= nw[i];
                            end
                        end
                        default: begin
                            for (int i = 0; i < 3; i++) begin
                                r_front[i] <= to_q14(r_fn[i]);
                                r_right[i] <= to_q14(r_rn[i]);
                                r_up[i]    <= to_q14(nw[i]);
                            end
                        end
                    endcase
                end
                S_U0: r_v[0] <= m_p[61:30];
                S_U1: r_acc <= m_p[63:0];
                S_U2: r_v[1] <= u_diff[61:30];
                S_U3: begin
                    r_v[2] <= m_p[61:30];
                    r_nsel <= NSEL_UP;
                    r_idx  <= 2'd0;
                end
                S_EMIT: begin
                    if (!i_out_stall) begin
                        r_grp <= r_grp + 3'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---- result channel ----
    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = (r_state == S_EMIT);
    assign o_which_group = r_grp;
    assign o_last_of_run = (r_grp == GRP_ANG);

    always_comb begin
        unique case (r_grp)
            GRP_POS: begin
                o_comp_a = r_pos[0];
                o_comp_b = r_pos[1];
                o_comp_c = r_pos[2];
            end
            GRP_FRONT: begin
                o_comp_a = 32'(r_front[0]);
                o_comp_b = 32'(r_front[1]);
                o_comp_c = 32'(r_front[2]);
            end
            GRP_RIGHT: begin
                o_comp_a = 32'(r_right[0]);
                o_comp_b = 32'(r_right[1]);
                o_comp_c = 32'(r_right[2]);
            end
            GRP_UP: begin
                o_comp_a = 32'(r_up[0]);
                o_comp_b = 32'(r_up[1]);
                o_comp_c = 32'(r_up[2]);
            end
            GRP_ANG: begin
                o_comp_a = 32'(r_yaw);
                o_comp_b = 32'(r_pitch);
                o_comp_c = 32'(r_zoom);
            end
            default: begin
                o_comp_a = '0;
                o_comp_b = '0;
                o_comp_c = '0;
            end
        endcase
    end

endmodule

// ===== tb/sv/fly_camera_orientation_update_tb.sv =====
// ----------------------------------------------------------------------------
// fly_camera_orientation_update_tb
// Self-checking bench for the fly camera orientation update. Directed events
// (extremes, every action and direction, clamps and wraps) and then random
// events go in through the valid/stall channel; a bit-exact camera predictor
// builds the five expected results of each event, which are checked field by
// field as the block reports them, under random idling on both sides.
// ----------------------------------------------------------------------------
module fly_camera_orientation_update_tb;
    import fcou_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS     = CORDIC_STEPS_DEF;
    localparam int N_RANDOM  = 330;
    localparam int CYC_LIMIT = 1500000;

    typedef struct packed {
        logic [2:0]         grp;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic               last;
    } t_report;

    typedef struct packed {
        logic [1:0]         act;
        logic [2:0]         dir;
        logic [15:0]        dt;
        logic signed [15:0] xo;
        logic signed [15:0] yo;
    } t_event;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [31:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_action;
    logic [2:0]         i_move_dir;
    logic [15:0]        i_delta_time;
    logic signed [15:0] i_x_offset;
    logic signed [15:0] i_y_offset;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [2:0]         o_which_group;
    logic signed [31:0] o_comp_a;
    logic signed [31:0] o_comp_b;
    logic signed [31:0] o_comp_c;
    logic               o_last_of_run;

    fly_camera_orientation_update DUT (.*);

    // camera predictor state
    longint cfg_sx, cfg_sy, cfg_sz, cfg_syaw, cfg_spitch, cfg_speed, cfg_sens;
    longint pos[3];
    longint yaw, pitch, zoom;
    longint fv[3], rv[3], uv[3];

    t_report camera_reports[$];
    int      n_errors;
    int      n_events;
    int      n_reports;
    longint  cycle;
    bit      quiet_out;
    bit      hold_out;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > CYC_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rshr(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint wrap_angle(longint v);
        longint r;
        r = (v + YAW_HALF) % YAW_SPAN;
        if (r < 0) r += YAW_SPAN;
        return r - YAW_HALF;
    endfunction

    function automatic longint arctan_step(int i);
        longint t[24] = '{188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
                          3754631, 1877430, 938729, 469366, 234683, 117342,
                          58671, 29335, 14668, 7334, 3667, 1833,
                          917, 458, 229, 115, 57, 29};
        return t[i];
    endfunction

    task automatic rotate(input longint ang, output longint c, output longint s);
        bit     flip;
        longint x, y, z, nx;
        flip = 0;
        x = CORDIC_K;
        y = 0;
        if (ang > ANG_90) begin
            ang -= 2 * ANG_90;
            flip = 1;
        end else if (ang < -ANG_90) begin
            ang += 2 * ANG_90;
            flip = 1;
        end
        z = ang * 32768;
        for (int i = 0; i < STEPS && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - fshr(y, i);
                y  = y + fshr(x, i);
                z -= arctan_step(i);
            end else begin
                nx = x + fshr(y, i);
                y  = y - fshr(x, i);
                z += arctan_step(i);
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    task automatic unit_vec(input longint v[3], output longint o[3], output bit ok);
        longint unsigned sum;
        longint len;
        sum = 0;
        for (int i = 0; i < 3; i++) sum += longint'(v[i] * v[i]);
        len = int_sqrt(sum);
        ok = len != 0;
        for (int i = 0; i < 3; i++) o[i] = ok ? (v[i] * (longint'(1) << 30)) / len : 0;
    endtask

    function automatic longint q14(longint v);
        return clampl(rshr(v, 16), -32768, 32767);
    endfunction

    task automatic rebuild_basis();
        longint cy, sy, cp, sp;
        longint f[3], fn[3], r[3], rn[3], u[3], un[3];
        bit     ok;
        rotate(yaw, cy, sy);
        rotate(pitch, cp, sp);
        f = '{fshr(cy * cp, 30), sp, fshr(sy * cp, 30)};
        unit_vec(f, fn, ok);
        if (!ok) fn = '{0, 0, -(longint'(1) << 30)};
        r = '{-fn[2], 0, fn[0]};
        unit_vec(r, rn, ok);
        if (!ok) rn = '{longint'(1) << 30, 0, 0};
        u[0] = fshr(-rn[2] * fn[1], 30);
        u[1] = fshr(rn[2] * fn[0] - rn[0] * fn[2], 30);
        u[2] = fshr(rn[0] * fn[1], 30);
        unit_vec(u, un, ok);
        if (!ok) un = '{0, longint'(1) << 30, 0};
        for (int i = 0; i < 3; i++) begin
            fv[i] = q14(fn[i]);
            rv[i] = q14(rn[i]);
            uv[i] = q14(un[i]);
        end
    endtask

    task automatic camera_reset();
        cfg_sx = 0; cfg_sy = 0; cfg_sz = 0;
        cfg_syaw = YAW_RST; cfg_spitch = 0;
        cfg_speed = SPEED_RST; cfg_sens = SENS_RST;
        pos = '{0, 0, 0};
        yaw = YAW_RST; pitch = 0; zoom = ZOOM_MAX;
        fv = '{0, 0, -ONE_Q14};
        rv = '{ONE_Q14, 0, 0};
        uv = '{0, ONE_Q14, 0};
    endtask

    task automatic camera_step(input t_event ev);
        longint ofs, sgn, dx, dy;
        longint v[3];
        bit     moves;
        if (ev.act == ACT_MOVE) begin
            ofs = cfg_speed * longint'(ev.dt);
            moves = 1;
            sgn = 1;
            case (ev.dir)
                DIR_FWD:   v = fv;
                DIR_BACK:  begin v = fv; sgn = -1; end
                DIR_LEFT:  begin v = rv; sgn = -1; end
                DIR_RIGHT: v = rv;
                DIR_UP:    v = uv;
                DIR_DOWN:  begin v = uv; sgn = -1; end
                default:   moves = 0;
            endcase
            if (moves)
                for (int i = 0; i < 3; i++)
                    pos[i] = clampl(pos[i] + sgn * rshr(v[i] * ofs, 22),
                                    -64'sd2147483648, 64'sd2147483647);
        end else if (ev.act == ACT_TURN) begin
            dx = rshr(longint'(ev.xo) * cfg_sens, 9);
            dy = rshr(longint'(ev.yo) * cfg_sens, 9);
            yaw = wrap_angle(yaw + dx);
            pitch = clampl(pitch + dy, -PITCH_LIM, PITCH_LIM);
            rebuild_basis();
        end else if (ev.act == ACT_ZOOM) begin
            zoom = clampl(zoom - longint'(ev.yo) * 8, ZOOM_MIN, ZOOM_MAX);
        end else begin
            pos = '{cfg_sx, cfg_sy, cfg_sz};
            yaw = wrap_angle(cfg_syaw);
            pitch = clampl(cfg_spitch, -PITCH_LIM, PITCH_LIM);
            zoom = ZOOM_MAX;
            rebuild_basis();
        end
        camera_reports.push_back({GRP_POS, 32'(pos[0]), 32'(pos[1]), 32'(pos[2]), 1'b0});
        camera_reports.push_back({GRP_FRONT, 32'(fv[0]), 32'(fv[1]), 32'(fv[2]), 1'b0});
        camera_reports.push_back({GRP_RIGHT, 32'(rv[0]), 32'(rv[1]), 32'(rv[2]), 1'b0});
        camera_reports.push_back({GRP_UP, 32'(uv[0]), 32'(uv[1]), 32'(uv[2]), 1'b0});
        camera_reports.push_back({GRP_ANG, 32'(yaw), 32'(pitch), 32'(zoom), 1'b1});
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_START_X:     cfg_sx = longint'($signed(val));
            CFG_START_Y:     cfg_sy = longint'($signed(val));
            CFG_START_Z:     cfg_sz = longint'($signed(val));
            CFG_START_YAW:   cfg_syaw = longint'($signed(val[15:0]));
            CFG_START_PITCH: cfg_spitch = longint'($signed(val[14:0]));
            CFG_MOVE_SPEED:  cfg_speed = longint'(val[15:0]);
            CFG_TURN_SENS:   cfg_sens = longint'(val[15:0]);
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (camera_reports.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // offer one event; gaps in front of it at random
    task automatic send_event(input t_event ev, input bit gaps);
        if (gaps)
            while ($urandom_range(99) < 10) @(posedge i_clk);
        i_in_valid   <= 1'b1;
        i_action     <= ev.act;
        i_move_dir   <= ev.dir;
        i_delta_time <= ev.dt;
        i_x_offset   <= ev.xo;
        i_y_offset   <= ev.yo;
        do @(posedge i_clk); while (o_in_stall);
        camera_step(ev);
        n_events++;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_event random_event();
        t_event ev;
        int     r;
        ev.dir = 3'($urandom_range(7));
        ev.dt  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2000));
        ev.xo  = 16'($urandom);
        ev.yo  = 16'($urandom);
        r = $urandom_range(99);
        if (r < 45) begin
            ev.act = ACT_MOVE;
        end else if (r < 75) begin
            ev.act = ACT_TURN;
            if ($urandom_range(1)) begin
                ev.xo = 16'($signed(12'($urandom)));
                ev.yo = 16'($signed(12'($urandom)));
            end
        end else if (r < 92) begin
            ev.act = ACT_ZOOM;
            if ($urandom_range(1)) ev.yo = 16'($signed(10'($urandom)));
        end else begin
            ev.act = ACT_RESTART;
        end
        return ev;
    endfunction

    // output side: random stall, a long hold when asked, and the checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= hold_out || (!quiet_out && $urandom_range(99) < 10);
        end
    end

    always @(posedge i_clk) begin
        t_report exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_reports++;
            if (camera_reports.size() == 0) begin
                $error("result with nothing expected: group %0d", o_which_group);
                n_errors++;
            end else begin
                exp_r = camera_reports.pop_front();
                if (o_which_group !== exp_r.grp) begin
                    $error("which_group exp %0d got %0d", exp_r.grp, o_which_group);
                    n_errors++;
                end
                if (o_comp_a !== exp_r.a) begin
                    $error("comp_a exp %0d got %0d", exp_r.a, o_comp_a);
                    n_errors++;
                end
                if (o_comp_b !== exp_r.b) begin
                    $error("comp_b exp %0d got %0d", exp_r.b, o_comp_b);
                    n_errors++;
                end
                if (o_comp_c !== exp_r.c) begin
                    $error("comp_c exp %0d got %0d", exp_r.c, o_comp_c);
                    n_errors++;
                end
                if (o_last_of_run !== exp_r.last) begin
                    $error("last_of_run exp %0d got %0d", exp_r.last, o_last_of_run);
                    n_errors++;
                end
            end
        end
    end

    // directed events; first rows read straight off the reset camera
    t_event  directed[] = '{
        '{ACT_ZOOM, DIR_FWD, 16'd0, 16'sd0, 16'sd0},
        '{ACT_MOVE, DIR_FWD, 16'hffff, 16'sd0, 16'sd0},
        '{ACT_MOVE, DIR_BACK, 16'd1000, 16'sh7fff, 16'sh8000},
        '{ACT_MOVE, DIR_LEFT, 16'd4000, 16'sd0, 16'sd0},
        '{ACT_MOVE, DIR_RIGHT, 16'd0, 16'sd0, 16'sd0},
        '{ACT_MOVE, DIR_UP, 16'd3000, 16'sd0, 16'sd0},
        '{ACT_MOVE, DIR_DOWN, 16'd500, 16'sd0, 16'sd0},
        '{ACT_MOVE, 3'd6, 16'hffff, 16'sd0, 16'sd0},
        '{ACT_MOVE, 3'd7, 16'hffff, 16'sd0, 16'sd0},
        '{ACT_ZOOM, 3'd7, 16'hffff, 16'sh7fff, 16'sh7fff},
        '{ACT_ZOOM, DIR_FWD, 16'd0, 16'sd0, 16'sh8000},
        '{ACT_ZOOM, DIR_FWD, 16'd0, 16'sd0, 16'sd100},
        '{ACT_TURN, DIR_FWD, 16'hffff, 16'sd0, 16'sd0},
        '{ACT_TURN, DIR_FWD, 16'd0, 16'sd1600, 16'sd400},
        '{ACT_TURN, DIR_FWD, 16'd0, 16'sh7fff, 16'sh7fff},
        '{ACT_TURN, DIR_FWD, 16'd0, 16'sh8000, 16'sh8000},
        '{ACT_TURN, DIR_FWD, 16'd0, -16'sd2300, 16'sd9000},
        '{ACT_MOVE, DIR_FWD, 16'hffff, 16'sd0, 16'sd0},
        '{ACT_MOVE, DIR_UP, 16'hffff, 16'sd0, 16'sd0},
        '{ACT_RESTART, 3'd7, 16'hffff, 16'sh7fff, 16'sh7fff}
    };
    // expected angle-group zoom for the first rows, straight from reset
    logic signed [31:0] directed_zoom[3] = '{ZOOM_MAX, ZOOM_MAX, ZOOM_MAX};

    initial begin
        t_event ev;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        i_in_valid = 1'b0; i_action = '0; i_move_dir = '0; i_delta_time = '0;
        i_x_offset = '0; i_y_offset = '0;
        cycle = 0; n_errors = 0; n_events = 0; n_reports = 0;
        quiet_out = 0; hold_out = 0;
        camera_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset camera: a zero zoom reports the reset values unchanged
        send_event(directed[0], 0);
        drain();
        if (zoom != directed_zoom[0] || yaw != YAW_RST || fv[2] != -ONE_Q14) begin
            $error("reset camera exp zoom %0d got %0d", directed_zoom[0], zoom);
            n_errors++;
        end

        // fast speed, sensitive mouse, extreme start point
        write_reg(CFG_MOVE_SPEED, 32'hffff);
        write_reg(CFG_TURN_SENS, 32'hffff);
        write_reg(CFG_START_X, 32'h7fff_ffff);
        write_reg(CFG_START_Y, 32'h8000_0000);
        write_reg(CFG_START_Z, 32'h0001_8000);
        write_reg(CFG_START_YAW, 32'h0000_5a00);
        write_reg(CFG_START_PITCH, 32'h0000_4000);
        for (int i = 1; i < directed.size(); i++) send_event(directed[i], 0);
        drain();
        write_reg(CFG_START_YAW, 32'h0000_a600);
        write_reg(CFG_START_PITCH, 32'h0000_3fff);
        send_event('{ACT_RESTART, DIR_FWD, 16'd0, 16'sd0, 16'sd0}, 0);
        send_event('{ACT_MOVE, DIR_BACK, 16'hffff, 16'sd0, 16'sd0}, 0);
        drain();

        // random phases, registers changed between them
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(CFG_MOVE_SPEED, ph == 0 ? 32'd0 : 32'($urandom));
            write_reg(CFG_TURN_SENS, ph == 1 ? 32'd0 : 32'($urandom_range(4000)));
            write_reg(CFG_START_X, $urandom);
            write_reg(CFG_START_Y, $urandom);
            write_reg(CFG_START_Z, $urandom);
            write_reg(CFG_START_YAW, 32'($urandom_range(46079)) - 32'd23040);
            write_reg(CFG_START_PITCH, 32'($urandom));
            quiet_out = (ph == 2);
            for (int n = 0; n < N_RANDOM / 5; n++) begin
                if (ph == 3 && n == 10) begin
                    // receiver holds off while events keep coming
                    hold_out = 1;
                    fork
                        begin
                            repeat (2000) @(posedge i_clk);
                            hold_out = 0;
                        end
                    join_none
                end
                if (ph == 4 && n == 20) drain();
                ev = random_event();
                send_event(ev, ph != 2);
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        $display("Covered %0d camera events and %0d checked results across five phases.",
                 n_events, n_reports);
        if (n_errors == 0 && camera_reports.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/fcou_pkg.sv
hw/rtl/fcou_sqdiv.sv
hw/rtl/fly_camera_orientation_update.sv
tb/sv/fly_camera_orientation_update_tb.sv
